@@ rtl/core/twbc_pkg.sv @@
// Shared constants for the two-level write-back cache: field widths,
// command and register codes, reset costs and default geometry.
// No dependencies.
package twbc_pkg;

  localparam int unsigned DEF_ADDR_BITS      = 18;
  localparam int unsigned DEF_L1_LINES       = 256;
  localparam int unsigned DEF_L2_LINES       = 512;
  localparam int unsigned DEF_WORDS_PER_LINE = 16;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COST_W  = 13;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_L1_RD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L1_WR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L2_RD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_L2_WR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_RD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_WR = 3'd5;

  localparam logic [CFG_W-1:0] RST_L1_RD  = 10'd1;
  localparam logic [CFG_W-1:0] RST_L1_WR  = 10'd1;
  localparam logic [CFG_W-1:0] RST_L2_RD  = 10'd10;
  localparam logic [CFG_W-1:0] RST_L2_WR  = 10'd10;
  localparam logic [CFG_W-1:0] RST_MEM_RD = 10'd100;
  localparam logic [CFG_W-1:0] RST_MEM_WR = 10'd100;

endpackage

@@ rtl/core/two_level_write_back_cache.sv @@
// Two-level direct-mapped write-back cache. L1 hit, clear or unused command: the item
// passes the tag and done states; the result is registered on leaving the done state.
// Miss: add one or two mark reads and up to five line copies, each word by word
// through the single port of each data RAM. One item at a time; the next item is
// taken while a result waits. After reset a clearing pass over every main-memory
// word zeroes main memory and all line marks.
module two_level_write_back_cache
  import twbc_pkg::*;
#(
  parameter int unsigned ADDR_BITS      = DEF_ADDR_BITS,
  parameter int unsigned L1_LINES       = DEF_L1_LINES,
  parameter int unsigned L2_LINES       = DEF_L2_LINES,
  parameter int unsigned WORDS_PER_LINE = DEF_WORDS_PER_LINE
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [ADDR_BITS-1:0] address_i,
  input  logic [DATA_W-1:0]    write_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DATA_W-1:0]    read_data_o,
  output logic                 l1_hit_o,
  output logic                 l2_hit_o,
  output logic [COST_W-1:0]    access_cost_o,
  output logic [DATA_W-1:0]    time_total_o
);

  localparam int unsigned W   = ADDR_BITS - 2;
  localparam int unsigned OB  = $clog2(WORDS_PER_LINE);
  localparam int unsigned LB  = W - OB;
  localparam int unsigned I1  = $clog2(L1_LINES);
  localparam int unsigned I2  = $clog2(L2_LINES);
  localparam int unsigned T1  = LB - I1;
  localparam int unsigned T2  = LB - I2;
  localparam int unsigned CB  = OB + 1;
  localparam int unsigned M1W = T1 + 2;
  localparam int unsigned M2W = T2 + 2;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_TAG     = 4'd1;
  localparam logic [3:0] ST_AMARK   = 4'd2;
  localparam logic [3:0] ST_BMARK   = 4'd3;
  localparam logic [3:0] ST_CP_WB   = 4'd4;
  localparam logic [3:0] ST_CP_FILL = 4'd5;
  localparam logic [3:0] ST_CP_L2FB = 4'd6;
  localparam logic [3:0] ST_CP_VIC  = 4'd7;
  localparam logic [3:0] ST_CP_L1   = 4'd8;
  localparam logic [3:0] ST_DONE    = 4'd9;

  logic [3:0] state_q, state_d;
  logic       clr_q, clr_d;
  logic [W-1:0] clr_cnt_q, clr_cnt_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic       phase_q, phase_d;

  logic [CFG_W-1:0] l1_rd_q, l1_wr_q, l2_rd_q, l2_wr_q, mem_rd_q, mem_wr_q;

  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [LB-1:0]     line_q, line_d;
  logic [OB-1:0]     off_q, off_d;
  logic [DATA_W-1:0] wdata_q, wdata_d;
  logic              v1_q, v1_d;
  logic [T1-1:0]     vt1_q, vt1_d;
  logic [I2-1:0]     i2_q, i2_d;
  logic [LB-1:0]     wbline_q, wbline_d;
  logic [COST_W-1:0] cost_q, cost_d;
  logic              h1_q, h1_d, h2_q, h2_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [DATA_W-1:0] sum_q, sum_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_rdata_q, out_rdata_d, out_time_q, out_time_d;
  logic              out_h1_q, out_h1_d, out_h2_q, out_h2_d;
  logic [COST_W-1:0] out_cost_q, out_cost_d;

  // RAM ports
  logic                     l1d_we, l2d_we, mem_we, fb_we, l1m_we, l2m_we;
  logic [I1+OB-1:0]         l1d_addr;
  logic [I2+OB-1:0]         l2d_addr;
  logic [W-1:0]             main_addr;
  logic [OB-1:0]            fb_addr;
  logic [I1-1:0]            l1m_addr;
  logic [I2-1:0]            l2m_addr;
  logic [DATA_W-1:0]        l1d_wdata, l2d_wdata, mem_wdata, fb_wdata;
  logic [DATA_W-1:0]        l1d_rdata, l2d_rdata, mem_rdata, fb_rdata;
  logic [M1W-1:0]           l1m_wdata, l1m_rdata;
  logic [M2W-1:0]           l2m_wdata, l2m_rdata;

  twbc_ram #(.WIDTH(DATA_W), .DEPTH(L1_LINES * WORDS_PER_LINE)) u_l1d (
    .clk_i, .we_i(l1d_we), .addr_i(l1d_addr), .wdata_i(l1d_wdata), .rdata_o(l1d_rdata));
  twbc_ram #(.WIDTH(DATA_W), .DEPTH(L2_LINES * WORDS_PER_LINE)) u_l2d (
    .clk_i, .we_i(l2d_we), .addr_i(l2d_addr), .wdata_i(l2d_wdata), .rdata_o(l2d_rdata));
  twbc_ram #(.WIDTH(DATA_W), .DEPTH(2 ** W)) u_mem (
    .clk_i, .we_i(mem_we), .addr_i(main_addr), .wdata_i(mem_wdata), .rdata_o(mem_rdata));
  twbc_ram #(.WIDTH(DATA_W), .DEPTH(WORDS_PER_LINE)) u_fb (
    .clk_i, .we_i(fb_we), .addr_i(fb_addr), .wdata_i(fb_wdata), .rdata_o(fb_rdata));
  twbc_ram #(.WIDTH(M1W), .DEPTH(L1_LINES)) u_l1m (
    .clk_i, .we_i(l1m_we), .addr_i(l1m_addr), .wdata_i(l1m_wdata), .rdata_o(l1m_rdata));
  twbc_ram #(.WIDTH(M2W), .DEPTH(L2_LINES)) u_l2m (
    .clk_i, .we_i(l2m_we), .addr_i(l2m_addr), .wdata_i(l2m_wdata), .rdata_o(l2m_rdata));

  // address fields of the latched item and of the incoming one
  logic [W-1:0]  in_waddr;
  logic [LB-1:0] in_line;
  logic [OB-1:0] in_off;
  logic [I1-1:0] idx1;
  logic [T1-1:0] tag1;
  logic [I2-1:0] idx2;
  logic [T2-1:0] tag2;
  logic [LB-1:0] vline;
  logic [I2-1:0] vidx2;
  logic [T2-1:0] vtag2;
  logic [CB-1:0] cnt_m1;
  logic [OB-1:0] rd_off, wr_off;
  logic          wr_en, last;
  logic          in_acc, out_free;
  logic          m1_hit, m2_hit, m2_dirty;

  assign in_waddr = address_i[ADDR_BITS-1:2];
  assign in_line  = in_waddr[W-1:OB];
  assign in_off   = in_waddr[OB-1:0];
  assign idx1     = line_q[I1-1:0];
  assign tag1     = line_q[LB-1:I1];
  assign idx2     = line_q[I2-1:0];
  assign tag2     = line_q[LB-1:I2];
  assign vline    = {vt1_q, idx1};
  assign vidx2    = vline[I2-1:0];
  assign vtag2    = vline[LB-1:I2];
  assign cnt_m1   = cnt_q - CB'(1);
  assign rd_off   = cnt_q[OB-1:0];
  assign wr_off   = cnt_m1[OB-1:0];
  assign wr_en    = cnt_q != '0;
  assign last     = cnt_q == CB'(WORDS_PER_LINE);
  assign in_stall_o = clr_q || (state_q != ST_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign m1_hit   = l1m_rdata[M1W-1] && (l1m_rdata[T1-1:0] == tag1);
  assign m2_dirty = l2m_rdata[M2W-1] && l2m_rdata[M2W-2];

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    clr_cnt_d = clr_cnt_q;
    cnt_d = cnt_q;
    phase_d = phase_q;
    cmd_d = cmd_q;
    line_d = line_q;
    off_d = off_q;
    wdata_d = wdata_q;
    v1_d = v1_q;
    vt1_d = vt1_q;
    i2_d = i2_q;
    wbline_d = wbline_q;
    cost_d = cost_q;
    h1_d = h1_q;
    h2_d = h2_q;
    res_d = res_q;
    sum_d = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rdata_d = out_rdata_q;
    out_time_d = out_time_q;
    out_h1_d = out_h1_q;
    out_h2_d = out_h2_q;
    out_cost_d = out_cost_q;
    m2_hit = 1'b0;

    l1d_we = 1'b0; l1d_addr = {idx1, off_q}; l1d_wdata = wdata_q;
    l2d_we = 1'b0; l2d_addr = {i2_q, rd_off}; l2d_wdata = l1d_rdata;
    mem_we = 1'b0; main_addr = {wbline_q, wr_off}; mem_wdata = l2d_rdata;
    fb_we = 1'b0;  fb_addr = rd_off; fb_wdata = mem_rdata;
    l1m_we = 1'b0; l1m_addr = idx1; l1m_wdata = {1'b1, 1'b0, tag1};
    l2m_we = 1'b0; l2m_addr = idx2; l2m_wdata = {1'b1, 1'b0, tag2};

    if (clr_q) begin
      mem_we = 1'b1; main_addr = clr_cnt_q; mem_wdata = '0;
      l1m_we = 1'b1; l1m_addr = clr_cnt_q[I1-1:0]; l1m_wdata = '0;
      l2m_we = 1'b1; l2m_addr = clr_cnt_q[I2-1:0]; l2m_wdata = '0;
      clr_cnt_d = clr_cnt_q + W'(1);
      if (clr_cnt_q == '1) begin
        clr_d = 1'b0;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        l1m_addr = clr_q ? clr_cnt_q[I1-1:0] : in_line[I1-1:0];
        l1d_addr = {in_line[I1-1:0], in_off};
        if (in_acc) begin
          cmd_d = command_i;
          line_d = in_line;
          off_d = in_off;
          wdata_d = write_data_i;
          cost_d = '0;
          h1_d = 1'b0;
          h2_d = 1'b0;
          res_d = '0;
          state_d = ST_TAG;
        end
      end
      ST_TAG: begin
        if (cmd_q != CMD_READ && cmd_q != CMD_WRITE) begin
          state_d = ST_DONE;
        end else if (m1_hit) begin
          h1_d = 1'b1;
          if (cmd_q == CMD_WRITE) begin
            l1d_we = 1'b1;
            l1m_we = 1'b1;
            l1m_wdata = {1'b1, 1'b1, tag1};
            cost_d = cost_q + COST_W'(l1_wr_q);
          end else begin
            res_d = l1d_rdata;
            cost_d = cost_q + COST_W'(l1_rd_q);
          end
          state_d = ST_DONE;
        end else begin
          v1_d = l1m_rdata[M1W-1];
          vt1_d = l1m_rdata[T1-1:0];
          phase_d = 1'b0;
          state_d = ST_AMARK;
        end
      end
      ST_AMARK: begin
        // fetch of the missing line through L2
        m2_hit = l2m_rdata[M2W-1] && (l2m_rdata[T2-1:0] == tag2);
        h2_d = m2_hit;
        i2_d = idx2;
        wbline_d = {l2m_rdata[T2-1:0], idx2};
        cnt_d = '0;
        if (m2_hit) begin
          cost_d = cost_q + COST_W'(l2_rd_q);
          state_d = ST_CP_L2FB;
        end else begin
          l2m_we = 1'b1;
          cost_d = cost_q + COST_W'(l2_rd_q) + COST_W'(mem_rd_q)
                 + (m2_dirty ? COST_W'(mem_wr_q) : '0);
          state_d = m2_dirty ? ST_CP_WB : ST_CP_FILL;
        end
      end
      ST_BMARK: begin
        // write of the L1 victim into L2
        m2_hit = l2m_rdata[M2W-1] && (l2m_rdata[T2-1:0] == vtag2);
        l2m_addr = vidx2;
        l2m_we = 1'b1;
        l2m_wdata = {1'b1, 1'b1, vtag2};
        i2_d = vidx2;
        wbline_d = {l2m_rdata[T2-1:0], vidx2};
        phase_d = 1'b1;
        cnt_d = '0;
        cost_d = cost_q + COST_W'(l2_wr_q)
               + (m2_hit ? '0 : COST_W'(mem_rd_q))
               + ((!m2_hit && m2_dirty) ? COST_W'(mem_wr_q) : '0);
        state_d = (!m2_hit && m2_dirty) ? ST_CP_WB : ST_CP_VIC;
      end
      ST_CP_WB: begin
        l2d_addr = {i2_q, rd_off};
        mem_we = wr_en;
        main_addr = {wbline_q, wr_off};
        mem_wdata = l2d_rdata;
        cnt_d = last ? '0 : cnt_q + CB'(1);
        if (last) begin
          state_d = phase_q ? ST_CP_VIC : ST_CP_FILL;
        end
      end
      ST_CP_FILL, ST_CP_L2FB: begin
        if (state_q == ST_CP_FILL) begin
          main_addr = {line_q, rd_off};
          l2d_we = wr_en;
          l2d_addr = {i2_q, wr_off};
          l2d_wdata = mem_rdata;
          fb_wdata = mem_rdata;
        end else begin
          l2d_addr = {i2_q, rd_off};
          fb_wdata = l2d_rdata;
        end
        fb_we = wr_en;
        fb_addr = wr_off;
        cnt_d = last ? '0 : cnt_q + CB'(1);
        if (last) begin
          l2m_addr = vidx2;
          state_d = v1_q ? ST_BMARK : ST_CP_L1;
        end
      end
      ST_CP_VIC: begin
        l1d_addr = {idx1, rd_off};
        l2d_we = wr_en;
        l2d_addr = {i2_q, wr_off};
        l2d_wdata = l1d_rdata;
        cnt_d = last ? '0 : cnt_q + CB'(1);
        if (last) begin
          state_d = ST_CP_L1;
        end
      end
      ST_CP_L1: begin
        // install the line, merging the written word on the way
        fb_addr = rd_off;
        l1d_we = wr_en;
        l1d_addr = {idx1, wr_off};
        l1d_wdata = (cmd_q == CMD_WRITE && wr_off == off_q) ? wdata_q : fb_rdata;
        if (wr_en && wr_off == off_q && cmd_q == CMD_READ) begin
          res_d = fb_rdata;
        end
        cnt_d = last ? '0 : cnt_q + CB'(1);
        if (last) begin
          l1m_we = 1'b1;
          l1m_wdata = {1'b1, cmd_q == CMD_WRITE, tag1};
          cost_d = cost_q + COST_W'(cmd_q == CMD_WRITE ? l1_wr_q : l1_rd_q);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rdata_d = res_q;
          out_h1_d = h1_q;
          out_h2_d = h2_q;
          out_cost_d = cost_q;
          if (cmd_q == CMD_CLEAR) begin
            sum_d = '0;
          end else if (cmd_q == CMD_READ || cmd_q == CMD_WRITE) begin
            sum_d = sum_q + DATA_W'(cost_q);
          end
          out_time_d = sum_d;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      clr_q <= 1'b1;
      clr_cnt_q <= '0;
      cnt_q <= '0;
      phase_q <= 1'b0;
      sum_q <= '0;
      out_valid_q <= 1'b0;
      l1_rd_q <= RST_L1_RD;
      l1_wr_q <= RST_L1_WR;
      l2_rd_q <= RST_L2_RD;
      l2_wr_q <= RST_L2_WR;
      mem_rd_q <= RST_MEM_RD;
      mem_wr_q <= RST_MEM_WR;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      cnt_q <= cnt_d;
      phase_q <= phase_d;
      sum_q <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_L1_RD:  l1_rd_q <= cfg_data_i;
          REG_L1_WR:  l1_wr_q <= cfg_data_i;
          REG_L2_RD:  l2_rd_q <= cfg_data_i;
          REG_L2_WR:  l2_wr_q <= cfg_data_i;
          REG_MEM_RD: mem_rd_q <= cfg_data_i;
          REG_MEM_WR: mem_wr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    line_q <= line_d;
    off_q <= off_d;
    wdata_q <= wdata_d;
    v1_q <= v1_d;
    vt1_q <= vt1_d;
    i2_q <= i2_d;
    wbline_q <= wbline_d;
    cost_q <= cost_d;
    h1_q <= h1_d;
    h2_q <= h2_d;
    res_q <= res_d;
    out_rdata_q <= out_rdata_d;
    out_time_q <= out_time_d;
    out_h1_q <= out_h1_d;
    out_h2_q <= out_h2_d;
    out_cost_q <= out_cost_d;
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_rdata_q;
  assign l1_hit_o      = out_h1_q;
  assign l2_hit_o      = out_h2_q;
  assign access_cost_o = out_cost_q;
  assign time_total_o  = out_time_q;

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside the completion state");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CB'(WORDS_PER_LINE))
    else $error("line copy counter overran");

  a_hit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_h1_q && out_h2_q))
    else $error("L1 hit and L2 hit reported together");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> state_q == ST_IDLE && !out_valid_q)
    else $error("item in flight during clearing pass");

endmodule

@@ rtl/core/twbc_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module twbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ test/two_level_write_back_cache_checker.sv @@
// Checker for the two-level write-back cache: watches the configuration port and both
// item channels, keeps its own copy of both caches, memory and costs, and compares results.
// Depends on twbc_pkg.
module two_level_write_back_cache_checker
  import twbc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [17:0]       address_i,
  input  logic [DATA_W-1:0] write_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [DATA_W-1:0] read_data_i,
  input  logic              l1_hit_i,
  input  logic              l2_hit_i,
  input  logic [COST_W-1:0] access_cost_i,
  input  logic [DATA_W-1:0] time_total_i,
  output int                items_o,
  output int                results_o,
  output int                errors_o
);

  typedef logic [15:0][31:0] line_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        l1_hit;
    logic        l2_hit;
    logic [12:0] cost;
    logic [31:0] total;
  } access_result_t;

  line_t       l1_data [256];
  logic        l1_valid [256];
  logic        l1_dirty [256];
  logic [3:0]  l1_tag [256];
  line_t       l2_data [512];
  logic        l2_valid [512];
  logic        l2_dirty [512];
  logic [2:0]  l2_tag [512];
  logic [31:0] mem_words [65536];
  logic [31:0] time_sum;
  logic [9:0]  l1_rd_cost, l1_wr_cost, l2_rd_cost, l2_wr_cost, mem_rd_cost, mem_wr_cost;

  access_result_t pending_q [$];

  initial begin
    for (int i = 0; i < 65536; i++) mem_words[i] = '0;
    for (int i = 0; i < 256; i++) begin
      l1_valid[i] = 1'b0;
      l1_dirty[i] = 1'b0;
      l1_tag[i]   = '0;
      l1_data[i]  = '0;
    end
    for (int i = 0; i < 512; i++) begin
      l2_valid[i] = 1'b0;
      l2_dirty[i] = 1'b0;
      l2_tag[i]   = '0;
      l2_data[i]  = '0;
    end
    time_sum    = '0;
    l1_rd_cost  = RST_L1_RD;
    l1_wr_cost  = RST_L1_WR;
    l2_rd_cost  = RST_L2_RD;
    l2_wr_cost  = RST_L2_WR;
    mem_rd_cost = RST_MEM_RD;
    mem_wr_cost = RST_MEM_WR;
  end

  function automatic line_t mem_line_read(input logic [11:0] line_no);
    line_t l;
    for (int i = 0; i < 16; i++) l[i] = mem_words[{line_no, 4'(i)}];
    return l;
  endfunction

  function automatic void mem_line_write(input logic [11:0] line_no, input line_t l);
    for (int i = 0; i < 16; i++) mem_words[{line_no, 4'(i)}] = l[i];
  endfunction

  // Block transfer through L2; returns the L2 hit flag.
  function automatic logic l2_transfer(input logic [11:0] line_no, inout line_t blk,
                                       input logic wr, inout logic [31:0] cost);
    logic [8:0] idx;
    logic       hit;
    line_t      fresh;
    idx = line_no[8:0];
    hit = l2_valid[idx] && l2_tag[idx] == line_no[11:9];
    if (!hit) begin
      fresh = mem_line_read(line_no);
      cost += mem_rd_cost;
      if (l2_valid[idx] && l2_dirty[idx]) begin
        mem_line_write({l2_tag[idx], idx}, l2_data[idx]);
        cost += mem_wr_cost;
      end
      l2_data[idx]  = fresh;
      l2_valid[idx] = 1'b1;
      l2_tag[idx]   = line_no[11:9];
      l2_dirty[idx] = 1'b0;
    end
    if (wr) begin
      l2_data[idx]  = blk;
      l2_dirty[idx] = 1'b1;
      cost += l2_wr_cost;
    end else begin
      blk = l2_data[idx];
      cost += l2_rd_cost;
    end
    return hit;
  endfunction

  function automatic access_result_t cache_access(input logic [CMD_W-1:0] cmd,
                                                  input logic [17:0] addr,
                                                  input logic [31:0] wdata);
    access_result_t r;
    logic [11:0] line_no;
    logic [3:0]  off;
    logic [7:0]  idx;
    logic [31:0] cost;
    line_t       fresh, victim;
    logic        dummy;
    r = '0;
    cost = '0;
    line_no = addr[17:6];
    off = addr[5:2];
    idx = line_no[7:0];
    case (cmd)
      CMD_CLEAR: time_sum = '0;
      CMD_READ, CMD_WRITE: begin
        r.l1_hit = l1_valid[idx] && l1_tag[idx] == line_no[11:8];
        if (!r.l1_hit) begin
          fresh = '0;
          r.l2_hit = l2_transfer(line_no, fresh, 1'b0, cost);
          if (l1_valid[idx]) begin
            victim = l1_data[idx];
            dummy = l2_transfer({l1_tag[idx], idx}, victim, 1'b1, cost);
          end
          l1_data[idx]  = fresh;
          l1_valid[idx] = 1'b1;
          l1_tag[idx]   = line_no[11:8];
          l1_dirty[idx] = 1'b0;
        end
        if (cmd == CMD_WRITE) begin
          l1_data[idx][off] = wdata;
          l1_dirty[idx] = 1'b1;
          cost += l1_wr_cost;
        end else begin
          r.read_data = l1_data[idx][off];
          cost += l1_rd_cost;
        end
        time_sum += cost;
      end
      default: ;
    endcase
    r.cost  = cost[12:0];
    r.total = time_sum;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t want;
    if (!rst_ni) begin
      items_o   <= 0;
      results_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_L1_RD:  l1_rd_cost  = cfg_data_i;
          REG_L1_WR:  l1_wr_cost  = cfg_data_i;
          REG_L2_RD:  l2_rd_cost  = cfg_data_i;
          REG_L2_WR:  l2_wr_cost  = cfg_data_i;
          REG_MEM_RD: mem_rd_cost = cfg_data_i;
          REG_MEM_WR: mem_wr_cost = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (pending_q.size() == 0) begin
          if (errors_o < 10) $display("checker: result with no item outstanding");
          errors_o <= errors_o + 1;
        end else begin
          want = pending_q.pop_front();
          if (want.read_data !== read_data_i || want.l1_hit !== l1_hit_i ||
              want.l2_hit !== l2_hit_i || want.cost !== access_cost_i ||
              want.total !== time_total_i) begin
            if (errors_o < 10)
              $display("checker: result %0d: expected data %h l1 %b l2 %b cost %0d total %0d,",
                       results_o, want.read_data, want.l1_hit, want.l2_hit, want.cost,
                       want.total, " got data %h l1 %b l2 %b cost %0d total %0d",
                       read_data_i, l1_hit_i, l2_hit_i, access_cost_i, time_total_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_q.push_back(cache_access(command_i, address_i, write_data_i));
        items_o <= items_o + 1;
      end
    end
  end

endmodule

@@ test/two_level_write_back_cache_tb.sv @@
// Top of the cache testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on twbc_pkg, two_level_write_back_cache and two_level_write_back_cache_checker.
module two_level_write_back_cache_tb;
  import twbc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     command_i = CMD_READ;
  logic [17:0]          address_i = '0;
  logic [DATA_W-1:0]    write_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [DATA_W-1:0]    read_data_o;
  logic                 l1_hit_o, l2_hit_o;
  logic [COST_W-1:0]    access_cost_o;
  logic [DATA_W-1:0]    time_total_o;

  int items, results, errors;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_seen = 0;
  int rx_hold = 0;
  bit rx_hold_done = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  two_level_write_back_cache u_dut (.*);

  two_level_write_back_cache_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .command_i, .address_i, .write_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .read_data_i(read_data_o),
    .l1_hit_i(l1_hit_o), .l2_hit_i(l2_hit_o), .access_cost_i(access_cost_o),
    .time_total_i(time_total_o), .items_o(items), .results_o(results), .errors_o(errors)
  );

  // Receiver: random stalls, plus one long hold-off after a few hundred results.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) rx_seen <= rx_seen + 1;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_stall_i <= 1'b1;
    end else if (!rx_hold_done && rx_seen == 400) begin
      rx_hold_done <= 1'b1;
      rx_hold <= 300;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Drop valid, then wait until the counts include the last accepted item and every item has its result.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (items != results) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send(input logic [CMD_W-1:0] cmd, input logic [17:0] addr,
                      input logic [31:0] data);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    address_i    <= addr;
    write_data_i <= data;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic set_costs(input logic [9:0] l1r, l1w, l2r, l2w, mr, mw);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_L1_RD;  cfg_data_i <= l1r; @(posedge clk_i);
    cfg_index_i <= REG_L1_WR;  cfg_data_i <= l1w; @(posedge clk_i);
    cfg_index_i <= REG_L2_RD;  cfg_data_i <= l2r; @(posedge clk_i);
    cfg_index_i <= REG_L2_WR;  cfg_data_i <= l2w; @(posedge clk_i);
    cfg_index_i <= REG_MEM_RD; cfg_data_i <= mr;  @(posedge clk_i);
    cfg_index_i <= REG_MEM_WR; cfg_data_i <= mw;  @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly a small pool of lines that collide in L1 and L2, sometimes anywhere.
  function automatic logic [17:0] pick_address();
    logic [11:0] line_no;
    if ($urandom_range(99) < 15) return 18'($urandom);
    line_no = {3'($urandom_range(0, 3)), 1'($urandom), 8'($urandom_range(0, 7))};
    return {line_no, 6'($urandom)};
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 46) return CMD_READ;
    if (r < 94) return CMD_WRITE;
    if (r < 98) return CMD_CLEAR;
    return CMD_UNUSED;
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset costs, word extremes, conflicts and write-back paths
    send(CMD_READ,   18'h00000, 32'h0);
    send(CMD_WRITE,  18'h00000, 32'hffff_ffff);
    send(CMD_READ,   18'h00000, 32'h0);
    send(CMD_WRITE,  18'h3fffc, 32'h0000_0000);
    send(CMD_READ,   18'h3ffff, 32'hffff_ffff);
    send(CMD_UNUSED, 18'h15555, 32'haaaa_aaaa);
    send(CMD_CLEAR,  18'h2aaaa, 32'h5555_5555);
    send(CMD_READ,   18'h04000, 32'h0);
    send(CMD_READ,   18'h00000, 32'h0);
    // victim landing on the L2 line just read
    send(CMD_READ,   18'h08000, 32'h0);
    send(CMD_READ,   18'h10000, 32'h0);
    send(CMD_READ,   18'h00000, 32'h0);
    send(CMD_WRITE,  18'h2aaa8, 32'h5555_5555);
    send(CMD_READ,   18'h2aaab, 32'h0);
    send(CMD_WRITE,  18'h15554, 32'haaaa_aaaa);
    send(CMD_READ,   18'h15554, 32'h0);
    send(CMD_CLEAR,  18'h00000, 32'h0);
    send(CMD_READ,   18'h3ffc0, 32'h0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_costs(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                     10'($urandom), 10'($urandom));
        1: set_costs(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        2: set_costs(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        default: set_costs(RST_L1_RD, RST_L1_WR, RST_L2_RD, RST_L2_WR, RST_MEM_RD,
                           RST_MEM_WR);
      endcase
      tx_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 75 : 0;
      rx_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 27 : 0;
      for (int n = 0; n < 258; n++) begin
        if (phase == 1 && n == 120) begin
          drain();
        end
        send(pick_command(), pick_address(), $urandom);
      end
      in_valid_i <= 1'b0;
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d items and %0d results over reset, random, zero and full costs,",
             items, results);
    $display("with L1 and L2 conflicts, write-backs, clears and stalls on both sides.");
    if (errors == 0) begin
      $display("two_level_write_back_cache verification clean");
    end else begin
      $display("two_level_write_back_cache verification failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout after %0d items and %0d results", items, results);
    $display("two_level_write_back_cache verification failed");
    $finish;
  end

endmodule
